### hdl/alte_pkg.sv
package alte_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int OP_W         = 3;
    localparam int POS_W        = 6;
    localparam int VAL_W        = 32;
    localparam int FOUND_W      = 5;
    localparam int CNT_W        = 6;
    localparam int LIMIT_W      = 6;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_LSRCH  = 3'd3,
        OP_BSRCH  = 3'd4
    } t_op;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp_res;

endpackage

### hdl/alte_cmp.sv
module alte_cmp (
    input  logic signed [alte_pkg::VAL_W-1:0] i_key,
    input  logic signed [alte_pkg::VAL_W-1:0] i_entry,
    output alte_pkg::t_cmp_res                o_res
);
    import alte_pkg::*;

    assign o_res.eq = (i_key == i_entry);
    assign o_res.lt = (i_key < i_entry);

endmodule

### hdl/alte_store.sv
module alte_store #(
    parameter int DEPTH = alte_pkg::CAPACITY_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [alte_pkg::VAL_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [alte_pkg::VAL_W-1:0] o_rdata
);
    import alte_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/alte_ctrl.sv
module alte_ctrl #(
    parameter int CAPACITY = alte_pkg::CAPACITY_DEF,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [alte_pkg::LIMIT_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [alte_pkg::OP_W-1:0]    i_op,
    input  logic [alte_pkg::POS_W-1:0]   i_position,
    input  logic [alte_pkg::VAL_W-1:0]   i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_ok,
    output logic [alte_pkg::VAL_W-1:0]   o_data_out,
    output logic [alte_pkg::FOUND_W-1:0] o_found_position,
    output logic [alte_pkg::CNT_W-1:0]   o_fill_count,
    output logic                         o_mem_we,
    output logic [AW-1:0]                o_mem_waddr,
    output logic [alte_pkg::VAL_W-1:0]   o_mem_wdata,
    output logic [AW-1:0]                o_mem_raddr,
    input  logic [alte_pkg::VAL_W-1:0]   i_mem_rdata
);
    import alte_pkg::*;

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CW1 = CW + 1;
    localparam int XW  = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_INS_WR,
        S_LSRCH,
        S_SWAP_A,
        S_SWAP_B,
        S_BS_PROBE,
        S_BS_CMP
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic [LIMIT_W-1:0]    r_limit;
    logic [VAL_W-1:0]      r_key;
    logic [AW-1:0]         r_pos;
    logic [AW-1:0]         r_rp;
    logic [AW-1:0]         r_rend;
    logic [AW-1:0]         r_pa;
    logic                  r_pend;
    logic                  r_rdone;
    logic                  r_del;
    logic                  r_done;
    logic [VAL_W-1:0]      r_first;
    logic                  r_ok;
    logic [VAL_W-1:0]      r_data;
    logic [AW-1:0]         r_found;
    logic [CW-1:0]         r_lo;
    logic signed [CW1-1:0] r_hi;
    logic                  r_ov;
    logic                  r_o_ok;
    logic [VAL_W-1:0]      r_o_data;
    logic [FOUND_W-1:0]    r_o_found;
    logic [CNT_W-1:0]      r_o_fill;

    logic [XW-1:0]  pos_x;
    logic [XW-1:0]  cnt_x;
    logic           room;
    logic           ins_ok;
    logic           del_ok;
    logic           at_end;
    logic           accept;
    logic           bs_go;
    logic [CW1-1:0] bs_sum;
    logic [AW-1:0]  bs_mid;
    logic           out_free;
    t_cmp_res       cmp;

    alte_cmp u_cmp (
        .i_key   (r_key),
        .i_entry (i_mem_rdata),
        .o_res   (cmp)
    );

    assign pos_x    = XW'(i_position);
    assign cnt_x    = XW'(r_count);
    assign room     = (cnt_x < XW'(r_limit)) && (cnt_x < XW'(CAPACITY));
    assign ins_ok   = room && (pos_x <= cnt_x);
    assign del_ok   = pos_x < cnt_x;
    assign at_end   = pos_x == cnt_x;
    assign accept   = i_in_valid && (r_state == S_IDLE) && !r_done;
    assign bs_go    = $signed(CW1'(r_lo)) <= r_hi;
    assign bs_sum   = CW1'(r_lo) + CW1'(r_hi[CW-1:0]);
    assign bs_mid   = bs_sum[AW:1];
    assign out_free = !r_ov || i_out_ready;

    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_pa;
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = (r_state == S_BS_PROBE) ? bs_mid : r_rp;
        unique case (r_state)
            S_IDLE: begin
                o_mem_waddr = AW'(r_count);
                o_mem_wdata = i_value;
                o_mem_we    = accept && (((i_op == OP_APPEND) && room) ||
                                         ((i_op == OP_INSERT) && ins_ok && at_end));
            end
            S_MOVE: begin
                if (r_del) begin
                    o_mem_waddr = r_pa - AW'(1);
                    o_mem_we    = r_pend && (r_pa != r_pos);
                end else begin
                    o_mem_waddr = r_pa + AW'(1);
                    o_mem_we    = r_pend;
                end
            end
            S_INS_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_pos;
                o_mem_wdata = r_key;
            end
            S_SWAP_A: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_found;
                o_mem_wdata = r_first;
            end
            S_SWAP_B: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = '0;
                o_mem_wdata = r_key;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_limit <= LIMIT_RESET;
            r_pend  <= 1'b0;
            r_rdone <= 1'b0;
            r_done  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (r_done && out_free) begin
                r_done    <= 1'b0;
                r_ov      <= 1'b1;
                r_o_ok    <= r_ok;
                r_o_data  <= r_data;
                r_o_found <= FOUND_W'(r_found);
                r_o_fill  <= CNT_W'(r_count);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_key   <= i_value;
                        r_ok    <= 1'b0;
                        r_data  <= '0;
                        r_found <= '0;
                        r_pend  <= 1'b0;
                        r_rdone <= 1'b0;
                        r_pos   <= AW'(pos_x);
                        case (i_op)
                            OP_APPEND: begin
                                r_done <= 1'b1;
                                if (room) begin
                                    r_ok    <= 1'b1;
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            OP_INSERT: begin
                                if (ins_ok && at_end) begin
                                    r_ok    <= 1'b1;
                                    r_count <= r_count + CW'(1);
                                    r_done  <= 1'b1;
                                end else if (ins_ok) begin
                                    r_del   <= 1'b0;
                                    r_rp    <= AW'(r_count - CW'(1));
                                    r_rend  <= AW'(pos_x);
                                    r_state <= S_MOVE;
                                end else begin
                                    r_done <= 1'b1;
                                end
                            end
                            OP_DELETE: begin
                                if (del_ok) begin
                                    r_del   <= 1'b1;
                                    r_rp    <= AW'(pos_x);
                                    r_rend  <= AW'(r_count - CW'(1));
                                    r_state <= S_MOVE;
                                end else begin
                                    r_data <= '1;
                                    r_done <= 1'b1;
                                end
                            end
                            OP_LSRCH: begin
                                if (r_count != '0) begin
                                    r_rp    <= '0;
                                    r_rend  <= AW'(r_count - CW'(1));
                                    r_state <= S_LSRCH;
                                end else begin
                                    r_done <= 1'b1;
                                end
                            end
                            OP_BSRCH: begin
                                r_lo    <= '0;
                                r_hi    <= CW1'(r_count) - CW1'(1);
                                r_state <= S_BS_PROBE;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_MOVE, S_LSRCH: begin
                    r_pa   <= r_rp;
                    r_pend <= !r_rdone;
                    if (!r_rdone) begin
                        if (r_rp == r_rend) begin
                            r_rdone <= 1'b1;
                        end else if (r_del || r_state == S_LSRCH) begin
                            r_rp <= r_rp + AW'(1);
                        end else begin
                            r_rp <= r_rp - AW'(1);
                        end
                    end
                    if (r_state == S_MOVE) begin
                        if (r_pend && r_del && (r_pa == r_pos)) begin
                            r_data <= i_mem_rdata;
                        end
                        if (r_pend && r_rdone) begin
                            if (r_del) begin
                                r_ok    <= 1'b1;
                                r_count <= r_count - CW'(1);
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                r_state <= S_INS_WR;
                            end
                        end
                    end else if (r_pend) begin
                        if (r_pa == '0) begin
                            r_first <= i_mem_rdata;
                        end
                        if (cmp.eq) begin
                            r_ok    <= 1'b1;
                            r_found <= r_pa;
                            r_state <= S_SWAP_A;
                        end else if (r_rdone) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_INS_WR: begin
                    r_ok    <= 1'b1;
                    r_count <= r_count + CW'(1);
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_SWAP_A: begin
                    r_state <= S_SWAP_B;
                end
                S_SWAP_B: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_BS_PROBE: begin
                    r_pa <= bs_mid;
                    if (bs_go) begin
                        r_state <= S_BS_CMP;
                    end else begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_BS_CMP: begin
                    if (cmp.eq) begin
                        r_ok    <= 1'b1;
                        r_found <= r_pa;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        if (cmp.lt) begin
                            r_hi <= $signed(CW1'(r_pa)) - CW1'(1);
                        end else begin
                            r_lo <= CW'(r_pa) + CW'(1);
                        end
                        r_state <= S_BS_PROBE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready       = (r_state == S_IDLE) && !r_done;
    assign o_out_valid      = r_ov;
    assign o_ok             = r_o_ok;
    assign o_data_out       = r_o_data;
    assign o_found_position = r_o_found;
    assign o_fill_count     = r_o_fill;

endmodule

### hdl/array_list_table_engine.sv
// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------------------
// in       | i_in_valid / o_in_ready   | i_op, i_position, i_value
// out      | o_out_valid / i_out_ready | o_ok, o_data_out, o_found_position, o_fill_count
// cfg      | i_cfg_we                  | i_cfg_data (capacity_limit)
//
// Append, insert at the end, refused commands and unknown ops finish straight from idle.
// Insert shifts the entries from the position upward, then writes the value; delete shifts
// the later entries down; linear search reads from entry 0 up; binary search probes and compares.
// The list RAM's single read port, one entry per cycle, paces the shifts and the linear search.
// Synchronous active-low reset clears the count, the limit (to 32) and control.
// A waiting result does not block the next transaction until its own result.
module array_list_table_engine #(
    parameter int CAPACITY = alte_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [alte_pkg::LIMIT_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [alte_pkg::OP_W-1:0]    i_op,
    input  logic [alte_pkg::POS_W-1:0]   i_position,
    input  logic signed [alte_pkg::VAL_W-1:0] i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_ok,
    output logic signed [alte_pkg::VAL_W-1:0] o_data_out,
    output logic [alte_pkg::FOUND_W-1:0] o_found_position,
    output logic [alte_pkg::CNT_W-1:0]   o_fill_count
);
    import alte_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_rdata;

    alte_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_ok             (o_ok),
        .o_data_out       (o_data_out),
        .o_found_position (o_found_position),
        .o_fill_count     (o_fill_count),
        .o_mem_we         (mem_we),
        .o_mem_waddr      (mem_waddr),
        .o_mem_wdata      (mem_wdata),
        .o_mem_raddr      (mem_raddr),
        .i_mem_rdata      (mem_rdata)
    );

    alte_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

### hdl/alte_chk.sv
module alte_chk #(
    parameter int CAPACITY = alte_pkg::CAPACITY_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic                              o_ok,
    input logic signed [alte_pkg::VAL_W-1:0] o_data_out,
    input logic [alte_pkg::FOUND_W-1:0]      o_found_position,
    input logic [alte_pkg::CNT_W-1:0]        o_fill_count
);
    import alte_pkg::*;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_fill_count) <= 32'(CAPACITY)))
        else $error("fill count above capacity");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_ok) &&
            $stable(o_data_out) && $stable(o_found_position) && $stable(o_fill_count)))
        else $error("result changed while stalled");

    a_fail_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> ((o_data_out == '0) || (o_data_out == '1)))
        else $error("failed transaction carries data");

    a_fail_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_found_position == '0))
        else $error("failed transaction carries a position");

endmodule

bind array_list_table_engine alte_chk #(.CAPACITY(CAPACITY)) u_chk (.*);
